// File: hw/rtl/lwkd_pkg.sv
// Shared constants and types for the longest-window letter counter.
// Used by lwkd_count_store and longest_window_k_distinct_letters.
package lwkd_pkg;

    localparam int MAX_LEN  = 1024;
    localparam int ALPHABET = 26;

    localparam int LETTER_W = 5;                       // letter field width
    localparam int K_W      = 5;                       // k_limit width
    localparam int CNT_W    = $clog2(MAX_LEN + 1);     // counts, positions up to MAX_LEN
    localparam int POS_W    = $clog2(MAX_LEN);         // history address
    localparam int LIDX_W   = $clog2(ALPHABET);        // count store address
    localparam int DIST_W   = $clog2(ALPHABET + 1);    // distinct letter tally

    localparam logic [K_W-1:0] K_RESET = K_W'(2);

    localparam int S_DATA_W = 8;
    localparam int M_DATA_W = 24;

    // Count store port: one read, one write and a bulk clear per cycle
    typedef struct packed {
        logic              rd_en;
        logic [LIDX_W-1:0] rd_addr;
        logic              wr_en;
        logic [LIDX_W-1:0] wr_addr;
        logic [CNT_W-1:0]  wr_data;
        logic              clr;
    } cnt_req_t;

endpackage

// File: hw/rtl/longest_window_k_distinct_letters.sv
// Longest window holding at most k_limit distinct letters over a letter stream.
// A new letter transfer is not taken while the previous one is still in stage 1:
// the count store has one read port and each letter reads two counts (its own
// and the one leaving the window start). The result for the transfer carrying
// tlast is formed in stage 1 and registered into a result slot. A result
// waiting on m_tready does not stop input: a second result slot is kept, and
// input is held back by results only when both are full. Counts clear at once
// through valid bits, so there is no clearing pass after reset or between
// strings. Letters 26..31 are ignored; letters past 1024 are dropped and
// reported through overflow. Depends on lwkd_pkg and lwkd_count_store.
module longest_window_k_distinct_letters
    import lwkd_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    // configuration: k_limit
    input  logic                cfg_wr_en,
    input  logic [K_W-1:0]      cfg_wr_data,
    // letter stream
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // [4:0] letter, [7:5] zero
    input  logic                s_tlast,   // last
    // result
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata    // [10:0] best_length, [20:11] best_start,
                                           // [21] too_few_unique, [22] overflow, [23] zero
);

    logic [K_W-1:0]      k_reg;
    logic [CNT_W-1:0]    item_cnt_reg;
    logic [CNT_W-1:0]    wb_reg;
    logic [CNT_W-1:0]    longest_reg;
    logic [POS_W-1:0]    lbegin_reg;
    logic                dropped_reg;
    logic [ALPHABET-1:0] seen_reg;
    logic [DIST_W-1:0]   distinct_reg;

    logic [LETTER_W-1:0] hist_mem [MAX_LEN];
    logic [LETTER_W-1:0] hist_q_reg;

    // stage 1: own count back, window start letter back
    logic                st1_valid_reg;
    logic                st1_take_reg;
    logic                st1_last_reg;
    logic                st1_hfwd_reg;
    logic [LETTER_W-1:0] st1_letter_reg;
    // stage 2: leaving letter's count back
    logic                st2_valid_reg;
    logic                st2_last_reg;
    logic                st2_rm_reg;
    logic [LETTER_W-1:0] st2_old_reg;

    logic                m_valid_reg;
    logic [M_DATA_W-1:0] m_data_reg;
    logic                skid_valid_reg;
    logic [M_DATA_W-1:0] skid_data_reg;

    logic                accept;
    logic [LETTER_W-1:0] in_letter;
    logic                in_alpha;
    logic                full;
    logic                take;
    cnt_req_t            creq;
    logic [CNT_W-1:0]    cnt_rd;
    logic [LETTER_W-1:0] old_letter;
    logic [DIST_W-1:0]   dist1;
    logic                rm;
    logic [DIST_W-1:0]   unique_cnt;
    logic                few;
    logic [CNT_W-1:0]    len_final;
    logic [POS_W-1:0]    begin_final;
    logic                res_push;
    logic [M_DATA_W-1:0] res_data;
    logic                pop;

    assign in_letter = s_tdata[LETTER_W-1:0];
    assign in_alpha  = in_letter < LETTER_W'(ALPHABET);
    assign full      = item_cnt_reg == CNT_W'(MAX_LEN);
    assign s_tready  = !st1_valid_reg && !skid_valid_reg;
    assign accept    = s_tvalid && s_tready;
    assign take      = accept && in_alpha && !full;

    // history: write the new letter, read the letter at the window start
    always_ff @(posedge aclk) begin
        if (take) begin
            hist_mem[item_cnt_reg[POS_W-1:0]] <= in_letter;
        end
        if (accept) begin
            hist_q_reg <= hist_mem[wb_reg[POS_W-1:0]];
        end
    end

    assign old_letter = st1_hfwd_reg ? st1_letter_reg : hist_q_reg;
    assign dist1      = distinct_reg + DIST_W'(cnt_rd == '0);
    assign rm         = st1_take_reg && (dist1 > DIST_W'(k_reg));

    always_comb begin
        creq         = '0;
        creq.rd_en   = take;
        creq.rd_addr = LIDX_W'(in_letter);
        if (st1_valid_reg && st1_take_reg) begin
            creq.wr_en   = 1'b1;
            creq.wr_addr = LIDX_W'(st1_letter_reg);
            creq.wr_data = cnt_rd + CNT_W'(1);
            creq.rd_en   = rm;
            creq.rd_addr = LIDX_W'(old_letter);
        end
        if (st2_valid_reg) begin
            if (st2_last_reg) begin
                creq.clr = 1'b1;
            end else if (st2_rm_reg && cnt_rd != '0) begin
                creq.wr_en   = 1'b1;
                creq.wr_addr = LIDX_W'(st2_old_reg);
                creq.wr_data = cnt_rd - CNT_W'(1);
            end
        end
    end

    lwkd_count_store u_count_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (creq),
        .rd_data (cnt_rd)
    );

    always_comb begin
        unique_cnt = '0;
        for (int i = 0; i < ALPHABET; i++) begin
            unique_cnt = unique_cnt + DIST_W'(seen_reg[i]);
        end
    end

    assign few         = unique_cnt < DIST_W'(k_reg);
    assign len_final   = (st1_take_reg && !rm) ? longest_reg + CNT_W'(1) : longest_reg;
    assign begin_final = (st1_take_reg && !rm) ? wb_reg[POS_W-1:0] : lbegin_reg;
    assign res_push    = st1_valid_reg && st1_last_reg;
    assign res_data    = {1'b0, dropped_reg, few,
                          few ? POS_W'(0) : begin_final,
                          few ? CNT_W'(0) : len_final};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            k_reg         <= K_RESET;
            item_cnt_reg  <= '0;
            wb_reg        <= '0;
            longest_reg   <= '0;
            lbegin_reg    <= '0;
            dropped_reg   <= 1'b0;
            seen_reg      <= '0;
            distinct_reg  <= '0;
            st1_valid_reg <= 1'b0;
            st2_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                k_reg <= cfg_wr_data;
            end
            st1_valid_reg <= accept;
            st2_valid_reg <= st1_valid_reg;

            if (take) begin
                item_cnt_reg <= item_cnt_reg + CNT_W'(1);
                for (int i = 0; i < ALPHABET; i++) begin
                    if (in_letter == LETTER_W'(i)) begin
                        seen_reg[i] <= 1'b1;
                    end
                end
            end
            if (accept && in_alpha && full) begin
                dropped_reg <= 1'b1;
            end

            if (st1_valid_reg) begin
                if (st1_last_reg) begin
                    // string done: restart position state
                    item_cnt_reg <= '0;
                    wb_reg       <= '0;
                    longest_reg  <= '0;
                    lbegin_reg   <= '0;
                    dropped_reg  <= 1'b0;
                    seen_reg     <= '0;
                end else if (st1_take_reg) begin
                    if (rm) begin
                        wb_reg <= wb_reg + CNT_W'(1);
                    end else begin
                        longest_reg <= longest_reg + CNT_W'(1);
                        lbegin_reg  <= wb_reg[POS_W-1:0];
                    end
                end
                if (st1_take_reg) begin
                    distinct_reg <= dist1;
                end
            end

            if (st2_valid_reg) begin
                if (st2_last_reg) begin
                    distinct_reg <= '0;
                end else if (st2_rm_reg && cnt_rd == CNT_W'(1)) begin
                    distinct_reg <= distinct_reg - DIST_W'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            st1_take_reg   <= take;
            st1_last_reg   <= s_tlast;
            st1_letter_reg <= in_letter;
            st1_hfwd_reg   <= wb_reg == item_cnt_reg;
        end
        if (st1_valid_reg) begin
            st2_last_reg <= st1_last_reg;
            st2_rm_reg   <= rm;
            st2_old_reg  <= old_letter;
        end
    end

    // output register with one skid slot behind it
    assign pop = m_valid_reg && m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!m_valid_reg || pop) begin
            if (skid_valid_reg) begin
                m_valid_reg    <= 1'b1;
                skid_valid_reg <= res_push;
            end else begin
                m_valid_reg <= res_push;
            end
        end else if (res_push) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!m_valid_reg || pop) begin
            if (skid_valid_reg) begin
                m_data_reg <= skid_data_reg;
                if (res_push) begin
                    skid_data_reg <= res_data;
                end
            end else if (res_push) begin
                m_data_reg <= res_data;
            end
        end else if (res_push) begin
            skid_data_reg <= res_data;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> !s_tready)
        else $error("transfer taken while previous letter still in stage 1");

    a_window_length: assert property (@(posedge aclk) disable iff (!aresetn)
        !st1_valid_reg |-> (item_cnt_reg - wb_reg == longest_reg))
        else $error("window length differs from recorded longest");

    a_skid_order: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> m_valid_reg)
        else $error("skid slot holds a result while output register is empty");

    a_no_push_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (skid_valid_reg && !pop) |-> !res_push)
        else $error("result produced with both result slots full");

endmodule

// File: hw/rtl/lwkd_count_store.sv
// Per-letter count memory with a registered read, write-to-read bypass
// and per-entry valid bits that clear all entries at once. Depends on lwkd_pkg.
module lwkd_count_store
    import lwkd_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  cnt_req_t         req,
    output logic [CNT_W-1:0] rd_data
);

    logic [CNT_W-1:0]    mem [ALPHABET];
    logic [ALPHABET-1:0] valid_reg;
    logic [ALPHABET-1:0] valid_next;
    logic [LIDX_W-1:0]   rd_addr_reg;
    logic [CNT_W-1:0]    q_reg;
    logic                byp_en_reg;
    logic [CNT_W-1:0]    byp_data_reg;

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en) begin
            q_reg       <= mem[req.rd_addr];
            rd_addr_reg <= req.rd_addr;
        end
        byp_data_reg <= req.wr_data;
    end

    always_comb begin
        valid_next = valid_reg;
        if (req.clr) begin
            valid_next = '0;
        end else if (req.wr_en) begin
            for (int i = 0; i < ALPHABET; i++) begin
                if (req.wr_addr == LIDX_W'(i)) begin
                    valid_next[i] = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg  <= '0;
            byp_en_reg <= 1'b0;
        end else begin
            valid_reg  <= valid_next;
            // memory returns pre-write data when read and write hit together
            byp_en_reg <= req.rd_en && req.wr_en && (req.rd_addr == req.wr_addr);
        end
    end

    // an entry never written since the last clear reads as zero
    assign rd_data = !valid_reg[rd_addr_reg] ? '0 :
                     byp_en_reg              ? byp_data_reg : q_reg;

    a_no_write_on_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        !(req.wr_en && req.clr))
        else $error("count store written and cleared in the same cycle");

    a_read_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        req.rd_en |-> (req.rd_addr < LIDX_W'(ALPHABET)))
        else $error("count store read beyond alphabet");

    a_bypass_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        byp_en_reg |-> valid_reg[rd_addr_reg])
        else $error("bypassed entry not marked valid");

endmodule
